@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each use clocks on clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/lpht_pkg.sv @@
package lpht_pkg;

	// Slot count; must be a power of two so that the probe index wraps by masking.
	localparam int CAPACITY = 256;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int UCNT_W   = IDX_W + 1;
	localparam int KEY_W    = 32;
	localparam int HASH_W   = 32;
	localparam int VAL_W    = 64;
	localparam int LIM_W    = 8;
	localparam int CMP_W    = ((UCNT_W > LIM_W) ? UCNT_W : LIM_W) + 1;

	localparam logic [LIM_W-1:0] FILL_LIMIT_RST = LIM_W'(192);

	typedef enum logic [1:0] {
		MODE_SET,
		MODE_GET,
		MODE_REMOVE,
		MODE_CLEAR
	} mode_t;

	typedef enum logic [1:0] {
		MARK_EMPTY,
		MARK_TOMB,
		MARK_FULL
	} mark_t;

	typedef enum logic [1:0] {
		STAT_DONE,
		STAT_MISS,
		STAT_FULL
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_PROBE
	} state_t;

	typedef struct packed {
		mark_t             mark;
		logic [KEY_W-1:0]  key;
	} entry_t;

	// Write port of the slot store.
	typedef struct packed {
		logic              entry_en;
		logic              value_en;
		logic [IDX_W-1:0]  addr;
		entry_t            entry;
		logic [VAL_W-1:0]  value;
	} wr_req_t;

	// Registered read data of the slot store; mark already reads empty for unwritten slots.
	typedef struct packed {
		entry_t            entry;
		logic [VAL_W-1:0]  value;
	} rd_data_t;

endpackage

@@ rtl/linear_probe_hash_table.sv @@
// Channel   Direction  Signals                                  Handshake
// request   in         mode, key_id, key_hash, value_in        start && !busy
// result    out        status, was_new, value_out              done, one cycle
// config    in         cfg_data (fill_limit)                   cfg_we
//
// A get, set or remove issues its first slot read as it is accepted, then probes the slots
// one at a time, P slots with P from 1 to 256, as the slot store has a single read port.
// The result strobe rises in the cycle after the final probe; busy falls with it.
// A clear is carried out as it is accepted; busy stays low and the strobe follows on the next cycle.
// Reset clears the slot valid bits at once, so no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "assert_macros.svh"

module linear_probe_hash_table import lpht_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        mode,
	input  logic [KEY_W-1:0]  key_id,
	input  logic [HASH_W-1:0] key_hash,
	input  logic [VAL_W-1:0]  value_in,
	input  logic              cfg_we,
	input  logic [LIM_W-1:0]  cfg_data,
	output logic              done,
	output logic [1:0]        status,
	output logic              was_new,
	output logic [VAL_W-1:0]  value_out
);

	// Fill limit register: counts tombstones and occupied slots alike.
	logic [LIM_W-1:0]  fill_limit_q;
	logic [IDX_W-1:0]  rd_addr;
	rd_data_t          rd;
	wr_req_t           wr;
	logic              clr;
	status_t           status_w;

	// Hold the limit; take a new one whenever the write enable is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_limit_q <= FILL_LIMIT_RST;
		end else if (cfg_we) begin
			fill_limit_q <= cfg_data;
		end
	end

	// Probe sequencer: walks slots, decides the outcome, drives the single write.
	lpht_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode_t'(mode)),
		.key_id     (key_id),
		.key_hash   (key_hash),
		.value_in   (value_in),
		.fill_limit (fill_limit_q),
		.rd_addr    (rd_addr),
		.rd         (rd),
		.wr         (wr),
		.clr        (clr),
		.done       (done),
		.status     (status_w),
		.was_new    (was_new),
		.value_out  (value_out)
	);

	// Slot store: mark and key in one memory, value in another, valid bit per slot.
	lpht_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd      (rd),
		.wr      (wr),
		.clr     (clr)
	);

	assign status = status_w;

	// Busy must never fall without a result strobe.
	`ASSERT_CLK(a_busy_until_done, !($past(busy) && !busy) || done, "busy fell without a result")

endmodule

@@ rtl/lpht_store.sv @@
`include "assert_macros.svh"

module lpht_store import lpht_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  rd_addr,
	output rd_data_t          rd,
	input  wr_req_t           wr,
	input  logic              clr
);

	entry_t            entry_mem [CAPACITY];
	logic [VAL_W-1:0]  value_mem [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	entry_t            entry_rd_q;
	logic [VAL_W-1:0]  value_rd_q;
	logic              valid_rd_q;

	always_ff @(posedge clk) begin
		if (wr.entry_en) begin
			entry_mem[wr.addr] <= wr.entry;
		end
		if (wr.value_en) begin
			value_mem[wr.addr] <= wr.value;
		end
		entry_rd_q <= entry_mem[rd_addr];
		value_rd_q <= value_mem[rd_addr];
	end

	// Valid bits: drop all on clear, set a slot when its entry is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr.entry_en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			valid_rd_q <= valid_q[rd_addr];
		end
	end

	always_comb begin
		rd.entry.key  = entry_rd_q.key;
		rd.entry.mark = valid_rd_q ? entry_rd_q.mark : MARK_EMPTY;
		rd.value      = value_rd_q;
	end

	`ASSERT_CLK(a_no_wr_on_clr, !(clr && (wr.entry_en || wr.value_en)), "write during clear")

endmodule

@@ rtl/lpht_ctrl.sv @@
`include "assert_macros.svh"

module lpht_ctrl import lpht_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mode_t             mode,
	input  logic [KEY_W-1:0]  key_id,
	input  logic [HASH_W-1:0] key_hash,
	input  logic [VAL_W-1:0]  value_in,
	input  logic [LIM_W-1:0]  fill_limit,
	output logic [IDX_W-1:0]  rd_addr,
	input  rd_data_t          rd,
	output wr_req_t           wr,
	output logic              clr,
	output logic              done,
	output status_t           status,
	output logic              was_new,
	output logic [VAL_W-1:0]  value_out
);

	state_t             state_q, state_d;
	mode_t              mode_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   value_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   cnt_q;
	logic               tomb_vld_q;
	logic [IDX_W-1:0]   tomb_idx_q;
	logic [UCNT_W-1:0]  used_q;
	logic               done_q;
	status_t            status_q;
	logic               was_new_q;
	logic [VAL_W-1:0]   value_out_q;

	logic               accept;
	logic [IDX_W-1:0]   idx_nxt;
	logic               is_empty, is_tomb, is_match, is_last;
	logic               fin;
	logic               hit_ok, hit_tomb;
	logic [IDX_W-1:0]   hit_idx;
	logic               over_limit;
	logic               rec_tomb;
	logic               used_inc;
	status_t            res_status;
	logic               res_new;
	logic [VAL_W-1:0]   res_value;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign idx_nxt = idx_q + IDX_W'(1);

	// Classify the slot just read.
	always_comb begin
		is_empty   = (rd.entry.mark == MARK_EMPTY);
		is_tomb    = (rd.entry.mark == MARK_TOMB);
		is_match   = (rd.entry.mark == MARK_FULL) && (rd.entry.key == key_q);
		is_last    = (cnt_q == IDX_W'(CAPACITY - 1));
		rec_tomb   = is_tomb && !tomb_vld_q;
		over_limit = (CMP_W'(used_q) + CMP_W'(1)) > CMP_W'(fill_limit);
		hit_idx    = tomb_vld_q ? tomb_idx_q : idx_q;
		priority if (is_match) begin
			hit_ok   = 1'b1;
			hit_tomb = 1'b0;
			hit_idx  = idx_q;
		end else if (is_empty) begin
			hit_ok   = 1'b1;
			hit_tomb = tomb_vld_q;
		end else begin
			hit_ok   = tomb_vld_q || rec_tomb;
			hit_tomb = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && mode != MODE_CLEAR) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (fin) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_addr     = key_hash[IDX_W-1:0];
		wr          = '0;
		wr.addr     = hit_idx;
		wr.entry.key = key_q;
		wr.value    = value_q;
		clr         = 1'b0;
		fin         = 1'b0;
		used_inc    = 1'b0;
		res_status  = STAT_DONE;
		res_new     = 1'b0;
		res_value   = '0;
		unique case (state_q)
			ST_IDLE: begin
				clr = accept && (mode == MODE_CLEAR);
			end
			ST_PROBE: begin
				rd_addr = idx_nxt;
				fin     = is_match || is_empty || is_last;
				if (fin) begin
					unique case (mode_q)
						MODE_SET: begin
							priority if (is_match) begin
								wr.value_en = 1'b1;
							end else if (!hit_ok) begin
								res_status = STAT_FULL;
							end else if (!hit_tomb && over_limit) begin
								res_status = STAT_FULL;
							end else begin
								wr.entry_en   = 1'b1;
								wr.value_en   = 1'b1;
								wr.entry.mark = MARK_FULL;
								used_inc      = !hit_tomb;
								res_new       = 1'b1;
							end
						end
						MODE_GET: begin
							if (is_match) begin
								res_value = rd.value;
							end else begin
								res_status = STAT_MISS;
							end
						end
						MODE_REMOVE: begin
							if (is_match) begin
								wr.entry_en   = 1'b1;
								wr.entry.mark = MARK_TOMB;
							end else begin
								res_status = STAT_MISS;
							end
						end
						default: res_status = STAT_DONE;
					endcase
				end
			end
			default: rd_addr = key_hash[IDX_W-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			key_q   <= key_id;
			value_q <= value_in;
			idx_q   <= key_hash[IDX_W-1:0];
			cnt_q   <= '0;
		end else if (state_q == ST_PROBE) begin
			idx_q <= idx_nxt;
			cnt_q <= cnt_q + IDX_W'(1);
		end
		if (state_q == ST_PROBE && rec_tomb) begin
			tomb_idx_q <= idx_q;
		end
		if (accept || fin) begin
			status_q    <= accept ? STAT_DONE : res_status;
			was_new_q   <= accept ? 1'b0 : res_new;
			value_out_q <= accept ? '0 : res_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tomb_vld_q <= 1'b0;
			used_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin || clr;
			if (accept) begin
				tomb_vld_q <= 1'b0;
			end else if (state_q == ST_PROBE && rec_tomb) begin
				tomb_vld_q <= 1'b1;
			end
			if (clr) begin
				used_q <= '0;
			end else if (used_inc) begin
				used_q <= used_q + UCNT_W'(1);
			end
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign was_new   = was_new_q;
	assign value_out = value_out_q;

	`ASSERT_IMPLIES(a_side_fields_zero, done_q && status_q != STAT_DONE,
		!was_new_q && value_out_q == '0, "side fields set on a failed request")
	`ASSERT_IMPLIES(a_new_only_on_set, done_q && was_new_q,
		mode_q == MODE_SET && status_q == STAT_DONE, "was_new outside a completed set")

endmodule

@@ tb/tb_linear_probe_hash_table.sv @@
module tb_linear_probe_hash_table;
	import lpht_pkg::*;

	// Cycle budget: about 1100 requests, each at most a full sweep of probing plus
	// random gaps, taken several times over.
	localparam int unsigned CYCLE_LIMIT = 1500000;
	// Longest single request: the issue of the first read, a full sweep of the table, the strobe.
	localparam int SWEEP_CYCLES = CAPACITY + 4;

	// One entry of the stimulus list: either a request or a new fill limit.
	typedef struct packed {
		logic              is_limit;
		logic [LIM_W-1:0]  limit;
		mode_t             op;
		logic [KEY_W-1:0]  key;
		logic [HASH_W-1:0] hash;
		logic [VAL_W-1:0]  value;
	} hreq_t;

	// What the table should answer to one request.
	typedef struct packed {
		status_t           status;
		logic              was_new;
		logic [VAL_W-1:0]  value;
	} answer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        mode = '0;
	logic [KEY_W-1:0]  key_id = '0;
	logic [HASH_W-1:0] key_hash = '0;
	logic [VAL_W-1:0]  value_in = '0;
	logic              cfg_we = 1'b0;
	logic [LIM_W-1:0]  cfg_data = '0;
	logic              done;
	logic [1:0]        status;
	logic              was_new;
	logic [VAL_W-1:0]  value_out;

	linear_probe_hash_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.key_id    (key_id),
		.key_hash  (key_hash),
		.value_in  (value_in),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.done      (done),
		.status    (status),
		.was_new   (was_new),
		.value_out (value_out)
	);

	// Shadow copy of the table, updated as each request is accepted.
	mark_t             shadow_mark [CAPACITY];
	logic [KEY_W-1:0]  shadow_key  [CAPACITY];
	logic [VAL_W-1:0]  shadow_val  [CAPACITY];
	logic [UCNT_W-1:0] shadow_used;
	logic [LIM_W-1:0]  shadow_limit;

	hreq_t   pending_reqs [$];   // requests and limit changes still to be driven
	answer_t due_answers  [$];   // one per accepted request, in order of acceptance
	hreq_t   cur_req;            // request currently on the input ports

	// asked and answered move only by nonblocking assignment, so every process
	// sees the counts as they stood before the current edge.
	int asked = 0;
	int answered = 0;
	int errors = 0;
	int missing = 0;
	int n_limits = 0;
	int n_done = 0;
	int n_miss = 0;
	int n_full = 0;
	int unsigned cycles = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	// Walk the probe run from hash modulo capacity. found says whether the key sits in
	// slot hit; otherwise hit is where a set would go (first tombstone passed, else
	// the empty slot that stopped the walk), or -1 when there is no such slot.
	function automatic void probe_slots(input logic [KEY_W-1:0] key,
			input logic [HASH_W-1:0] hash, output bit found, output int hit);
		int idx;
		int tomb;
		int n;
		bit stop;
		idx = int'(hash % CAPACITY);
		tomb = -1;
		found = 1'b0;
		hit = -1;
		stop = 1'b0;
		for (n = 0; n < CAPACITY && !stop; n++) begin
			if (shadow_mark[idx] == MARK_EMPTY) begin
				hit = (tomb >= 0) ? tomb : idx;
				stop = 1'b1;
			end else if (shadow_mark[idx] == MARK_TOMB) begin
				if (tomb < 0)
					tomb = idx;
			end else if (shadow_key[idx] == key) begin
				hit = idx;
				found = 1'b1;
				stop = 1'b1;
			end
			idx = (idx + 1) % CAPACITY;
		end
		if (!stop)
			hit = tomb;
	endfunction

	// Apply one request to the shadow table and return the answer it must give.
	function automatic answer_t answer_request(input hreq_t r);
		answer_t a;
		bit found;
		int hit;
		a.status = STAT_DONE;
		a.was_new = 1'b0;
		a.value = '0;
		found = 1'b0;
		hit = -1;
		if (r.op != MODE_CLEAR)
			probe_slots(r.key, r.hash, found, hit);
		case (r.op)
			MODE_SET: begin
				if (found) begin
					shadow_val[hit] = r.value;
				end else if (hit < 0) begin
					a.status = STAT_FULL;
				end else if (shadow_mark[hit] == MARK_TOMB) begin
					// a reused tombstone is already counted, so the limit never refuses it
					shadow_mark[hit] = MARK_FULL;
					shadow_key[hit] = r.key;
					shadow_val[hit] = r.value;
					a.was_new = 1'b1;
				end else if (shadow_used + 1 > shadow_limit) begin
					a.status = STAT_FULL;
				end else begin
					shadow_mark[hit] = MARK_FULL;
					shadow_key[hit] = r.key;
					shadow_val[hit] = r.value;
					shadow_used = shadow_used + UCNT_W'(1);
					a.was_new = 1'b1;
				end
			end
			MODE_GET: begin
				if (found)
					a.value = shadow_val[hit];
				else
					a.status = STAT_MISS;
			end
			MODE_REMOVE: begin
				// the tombstone keeps its place in the used count
				if (found)
					shadow_mark[hit] = MARK_TOMB;
				else
					a.status = STAT_MISS;
			end
			default: begin
				foreach (shadow_mark[i])
					shadow_mark[i] = MARK_EMPTY;
				shadow_used = '0;
			end
		endcase
		return a;
	endfunction

	task automatic add_req(input mode_t op, input logic [KEY_W-1:0] key,
			input logic [HASH_W-1:0] hash, input logic [VAL_W-1:0] value);
		hreq_t r;
		r.is_limit = 1'b0;
		r.limit = '0;
		r.op = op;
		r.key = key;
		r.hash = hash;
		r.value = value;
		pending_reqs.push_back(r);
	endtask

	task automatic add_limit(input logic [LIM_W-1:0] limit);
		hreq_t r;
		r = '0;
		r.is_limit = 1'b1;
		r.limit = limit;
		pending_reqs.push_back(r);
	endtask

	// One phase of random traffic under a fixed fill limit. Keys come from a pool
	// whose hashes crowd into a window of slots, so probe runs grow long and cross
	// tombstones. Sets bring fresh keys at the rate fresh_pct; gets and removes mostly name keys
	// already set, now and then one never set; spare weight gives clears. A few requests are pure noise.
	task automatic add_phase(input int limit, input int n, input int window,
			input int w_set, input int w_get, input int w_rem, input int fresh_pct);
		logic [KEY_W-1:0]  pool_key  [0:511];
		logic [HASH_W-1:0] pool_hash [0:511];
		logic [31:0]       raw;
		logic [7:0]        base;
		int                seen;
		int                pick;
		int                roll;
		int                i;
		mode_t             op;
		add_limit(LIM_W'(limit));
		base = 8'($urandom);
		seen = 0;
		for (i = 0; i < n; i++) begin
			raw = $urandom;
			pool_key[i] = $urandom;
			pool_hash[i] = {raw[31:8], 8'(base + 8'($urandom_range(0, window - 1)))};
		end
		if ($urandom_range(0, 1))
			pool_key[0] = '0;
		for (i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < w_set) begin
				op = MODE_SET;
				if (seen < n && $urandom_range(0, 99) < fresh_pct) begin
					pick = seen;
					seen++;
				end else begin
					pick = (seen > 0) ? $urandom_range(0, seen - 1) : 0;
				end
			end else if (roll < w_set + w_get + w_rem) begin
				op = (roll < w_set + w_get) ? MODE_GET : MODE_REMOVE;
				pick = $urandom_range(0, seen);
				if (pick >= n)
					pick = n - 1;
			end else begin
				op = MODE_CLEAR;
				pick = $urandom_range(0, n - 1);
			end
			if ($urandom_range(0, 99) < 4)
				add_req(op, $urandom, $urandom, {$urandom, $urandom});
			else
				add_req(op, pool_key[pick], pool_hash[pick], {$urandom, $urandom});
		end
	endtask

	// Driver: present one request at a time on start and hold it until the table
	// takes it. Predict the answer at the edge of acceptance. Write a new fill
	// limit only once every accepted request has been answered.
	always @(posedge clk) begin : drive_requests
		bit      took;
		bit      hold;
		bit      raise;
		bit      write_lim;
		bit      eager;
		hreq_t   head;
		answer_t ans;
		if (arst_n) begin
			took = start && !busy;
			hold = start && !took;
			raise = hold;
			write_lim = 1'b0;
			// a limit written at this edge applies to every later request
			if (cfg_we)
				shadow_limit = cfg_data;
			if (took) begin
				ans = answer_request(cur_req);
				due_answers.push_back(ans);
				asked <= asked + 1;
			end
			// keep the middle of the run free of gaps
			eager = (asked >= 400 && asked < 600);
			if (!hold && pending_reqs.size() > 0) begin
				if (pending_reqs[0].is_limit) begin
					if (!took && asked == answered && !busy && !done) begin
						head = pending_reqs.pop_front();
						cfg_data <= head.limit;
						write_lim = 1'b1;
						n_limits++;
					end
				end else if (eager || $urandom_range(0, 99) >= 36) begin
					cur_req = pending_reqs.pop_front();
					mode <= cur_req.op;
					key_id <= cur_req.key;
					key_hash <= cur_req.hash;
					value_in <= cur_req.value;
					raise = 1'b1;
				end
			end
			start <= raise;
			cfg_we <= write_lim;
		end
	end

	// Monitor: every strobe must match the oldest answer still due.
	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && done) begin
			if (answered >= asked) begin
				errors++;
				$display("%0t: result with no request outstanding: status %0d was_new %0d value %h",
					$time, status, was_new, value_out);
			end else begin
				want = due_answers[answered];
				if (status !== want.status) begin
					errors++;
					$display("%0t: request %0d status expected %0d got %0d",
						$time, answered, want.status, status);
				end
				if (was_new !== want.was_new) begin
					errors++;
					$display("%0t: request %0d was_new expected %0d got %0d",
						$time, answered, want.was_new, was_new);
				end
				if (value_out !== want.value) begin
					errors++;
					$display("%0t: request %0d value_out expected %h got %h",
						$time, answered, want.value, value_out);
				end
				case (want.status)
					STAT_DONE: n_done++;
					STAT_MISS: n_miss++;
					default:   n_full++;
				endcase
				answered <= answered + 1;
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("FAIL linear_probe_hash_table");
			$finish;
		end
	end

	initial begin : stimulus
		int waited;
		foreach (shadow_mark[i])
			shadow_mark[i] = MARK_EMPTY;
		shadow_used = '0;
		shadow_limit = FILL_LIMIT_RST;

		// Directed part at the reset limit: empty table, key zero, all-ones key
		// and hash, wrap from the last slot to the first, tombstone passed and reused.
		add_req(MODE_GET,    32'd5,        32'd0,        64'h5A5A_5A5A_5A5A_5A5A);
		add_req(MODE_REMOVE, 32'd5,        32'd0,        64'h0);
		add_req(MODE_SET,    32'd0,        32'd0,        {VAL_W{1'b1}});
		add_req(MODE_GET,    32'd0,        32'd0,        64'h0);
		add_req(MODE_SET,    32'd0,        32'd0,        64'h0);
		add_req(MODE_SET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001);
		add_req(MODE_SET,    32'd7,        32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF);
		add_req(MODE_GET,    32'd7,        32'hFFFF_FFFF, 64'h0);
		add_req(MODE_REMOVE, 32'd0,        32'd0,        64'h0);
		add_req(MODE_GET,    32'd7,        32'h0000_00FF, 64'h0);
		add_req(MODE_SET,    32'd9,        32'h0000_00FF, 64'hFEDC_BA98_7654_3210);
		add_req(MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
		add_req(MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
		add_req(MODE_GET,    32'd0,        32'd0,        64'h0);
		add_req(MODE_CLEAR,  32'hA5A5_A5A5, 32'h5A5A_5A5A, {VAL_W{1'b1}});
		add_req(MODE_GET,    32'd7,        32'hFFFF_FFFF, 64'h0);
		// Lowest limit: second new key refused, replace and tombstone reuse still pass.
		add_limit(LIM_W'(1));
		add_req(MODE_SET,    32'd1,        32'd10,       64'h1111);
		add_req(MODE_SET,    32'd2,        32'd10,       64'h2222);
		add_req(MODE_SET,    32'd1,        32'd10,       64'h3333);
		add_req(MODE_REMOVE, 32'd1,        32'd10,       64'h0);
		add_req(MODE_SET,    32'd2,        32'd10,       64'h4444);
		add_req(MODE_SET,    32'd3,        32'd200,      64'h5555);
		add_req(MODE_CLEAR,  32'd0,        32'd0,        64'h0);

		// Random phases: fill to the highest limit, then crowded windows at the reset
		// limit and at low limits, and a last phase at any limit.
		add_phase(255, 380, 256, 80, 12, 8, 90);
		add_phase(192, 230, 12, 40, 30, 27, 50);
		add_phase($urandom_range(8, 24), 230, 24, 45, 25, 27, 40);
		add_phase($urandom_range(1, 4), 100, 8, 45, 25, 25, 40);
		add_phase($urandom_range(1, 255), 110, 64, 50, 25, 22, 60);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Drain the list, then let every answer arrive and leave room for strays.
		while (pending_reqs.size() != 0 || start)
			@(negedge clk);
		waited = 0;
		while (asked != answered && waited < 4 * SWEEP_CYCLES) begin
			@(negedge clk);
			waited++;
		end
		repeat (SWEEP_CYCLES) @(negedge clk);
		if (asked != answered) begin
			missing = asked - answered;
			$display("%0t: %0d requests never answered", $time, missing);
		end

		$display("Checked %0d requests: %0d done, %0d not found, %0d refused as full,",
			answered, n_done, n_miss, n_full);
		$display("across %0d fill-limit settings; %0d mismatches", n_limits, errors);
		if (errors == 0 && missing == 0)
			$display("PASS linear_probe_hash_table");
		else
			$display("FAIL linear_probe_hash_table");
		$finish;
	end

endmodule
